// ===== hw/rtl/utf8dec_pkg.sv =====
// shared types and constants for the utf-8 code point decoder
package utf8dec_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CpW     = 21;
    localparam int unsigned CountW  = 3;
    localparam int unsigned MaxJobItems = 4;

    localparam logic [CpW-1:0] ReplCp = CpW'(21'h00FFFD);

    // byte classes: ascii, the three lead kinds and continuation
    localparam logic [0:0] AsciiTag = 1'b0;
    localparam logic [2:0] Lead2Tag = 3'b110;
    localparam logic [3:0] Lead3Tag = 4'b1110;
    localparam logic [4:0] Lead4Tag = 5'b11110;
    localparam logic [1:0] ContTag  = 2'b10;

    // sequence under assembly
    typedef struct packed {
        logic [CpW-1:0] partial_value;
        logic [1:0]     bytes_still_needed;
        logic [1:0]     continuations_taken;
    } seq_state_t;

    // results caused by one byte: replacements first, then an optional code point
    typedef struct packed {
        logic [CountW-1:0] item_cnt;
        logic              has_cp;
        logic [CpW-1:0]    cp;
        logic              text_end;
    } job_t;

endpackage

// ===== hw/rtl/utf8_codepoint_decoder_core.sv =====
// utf-8 byte stream to code point decoder, top level
// a byte passes the input reg, the job reg and the out reg before its first result shows on m_
// throughput: one byte per cycle while each byte yields at most one result and m_ready holds no result back
// a byte yielding n results (n up to 4) holds the result emitter until all n have been emitted
// bytes that only extend a sequence yield nothing
// reset: synchronous active-low aresetn empties all stages and returns to no pending sequence
module utf8_codepoint_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [utf8dec_pkg::ByteW-1:0] s_data_byte,
    input  logic                          s_text_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [utf8dec_pkg::CpW-1:0]   m_code_point,
    output logic                          m_is_replacement,
    output logic                          m_run_last,
    output logic                          m_text_done
);
    import utf8dec_pkg::*;

    // input register
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_end_reg;

    // decode state and pending job
    seq_state_t state_reg;
    seq_state_t state_next;
    job_t       job_reg;
    job_t       job_next;
    job_t       job_dec;

    // result register
    logic           m_valid_reg;
    logic [CpW-1:0] m_cp_reg;
    logic           m_repl_reg;
    logic           m_last_reg;
    logic           m_done_reg;

    logic out_load;
    logic job_emit;
    logic job_final;
    logic job_take;
    logic decode_fire;

    utf8dec_step u_step (
        .data_byte (in_byte_reg),
        .text_end  (in_end_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .job       (job_dec)
    );

    assign out_load    = !m_valid_reg || m_ready;
    assign job_emit    = (job_reg.item_cnt != '0) && out_load;
    assign job_final   = (job_reg.item_cnt == CountW'(1));
    assign job_take    = (job_reg.item_cnt == '0) || (job_final && out_load);
    assign decode_fire = in_valid_reg && job_take;
    assign s_ready     = !in_valid_reg || decode_fire;

    always_comb begin
        job_next = job_reg;
        if (job_emit) begin
            job_next.item_cnt = job_reg.item_cnt - CountW'(1);
        end
        if (decode_fire && (job_dec.item_cnt != '0)) begin
            job_next = job_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_text_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= '{default: '0};
            job_reg.item_cnt <= '0;
        end else begin
            if (decode_fire) begin
                state_reg <= state_next;
            end
            job_reg.item_cnt <= job_next.item_cnt;
        end
        job_reg.has_cp   <= job_next.has_cp;
        job_reg.cp       <= job_next.cp;
        job_reg.text_end <= job_next.text_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= (job_reg.item_cnt != '0);
        end
        if (job_emit) begin
            // the decoded code point, if any, is the final item of the job
            m_cp_reg   <= (job_final && job_reg.has_cp) ? job_reg.cp : ReplCp;
            m_repl_reg <= !(job_final && job_reg.has_cp);
            m_last_reg <= job_final;
            m_done_reg <= job_final && job_reg.text_end;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_code_point     = m_cp_reg;
    assign m_is_replacement = m_repl_reg;
    assign m_run_last       = m_last_reg;
    assign m_text_done      = m_done_reg;

    a_job_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        job_reg.item_cnt <= CountW'(MaxJobItems))
        else $error("job holds more results than one byte can cause");

    a_done_is_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_text_done |-> m_run_last)
        else $error("text_done on a result that is not the last of its byte");

    a_repl_value : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_replacement |-> m_code_point == ReplCp)
        else $error("replacement result without the replacement code point");

    a_end_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        decode_fire && in_end_reg |=> state_reg.bytes_still_needed == 2'd0)
        else $error("sequence still pending after end of text");

endmodule

// ===== hw/rtl/utf8dec_step.sv =====
// per-byte decode: next sequence state and the results the byte causes
module utf8dec_step (
    input  logic [utf8dec_pkg::ByteW-1:0] data_byte,
    input  logic                          text_end,
    input  utf8dec_pkg::seq_state_t       state_cur,
    output utf8dec_pkg::seq_state_t       state_nxt,
    output utf8dec_pkg::job_t             job
);
    import utf8dec_pkg::*;

    localparam seq_state_t IdleState = '{default: '0};

    logic                 is_cont;
    logic                 relead;
    logic [CountW-1:0]    rep_cnt;
    logic                 has_cp;
    logic [CpW-1:0]       cp;
    logic [CpW-1:0]       acc;
    logic [1:0]           need_dec;
    logic [1:0]           taken_inc;
    logic                 lead_ok;
    logic [1:0]           lead_need;
    logic [CpW-1:0]       lead_bits;
    logic [CountW-1:0]    rep_lead;
    seq_state_t           state_seq;

    assign is_cont   = (data_byte[7:6] == ContTag);
    assign acc       = {state_cur.partial_value[CpW-7:0], data_byte[5:0]};
    assign need_dec  = state_cur.bytes_still_needed - 2'd1;
    assign taken_inc = state_cur.continuations_taken + 2'd1;

    always_comb begin
        relead    = 1'b1;
        rep_cnt   = '0;
        has_cp    = 1'b0;
        cp        = ReplCp;
        state_seq = state_cur;
        if (state_cur.bytes_still_needed != 2'd0) begin
            if (is_cont) begin
                relead = 1'b0;
                if (need_dec == 2'd0) begin
                    has_cp    = 1'b1;
                    cp        = acc;
                    state_seq = IdleState;
                end else if (text_end) begin
                    // truncated at end of text
                    rep_cnt   = CountW'(taken_inc) + CountW'(1);
                    state_seq = IdleState;
                end else begin
                    state_seq = '{partial_value: acc, bytes_still_needed: need_dec,
                                  continuations_taken: taken_inc};
                end
            end else begin
                // broken sequence, failing byte is decoded again as a lead
                rep_cnt   = CountW'(state_cur.continuations_taken) + CountW'(1);
                state_seq = IdleState;
            end
        end
    end

    always_comb begin
        lead_ok   = 1'b1;
        lead_need = 2'd0;
        lead_bits = '0;
        priority if (data_byte[7] == AsciiTag) begin
            lead_ok = 1'b0;
        end else if (data_byte[7:5] == Lead2Tag) begin
            lead_need = 2'd1;
            lead_bits = CpW'(data_byte[4:0]);
        end else if (data_byte[7:4] == Lead3Tag) begin
            lead_need = 2'd2;
            lead_bits = CpW'(data_byte[3:0]);
        end else if (data_byte[7:3] == Lead4Tag) begin
            lead_need = 2'd3;
            lead_bits = CpW'(data_byte[2:0]);
        end else begin
            lead_ok = 1'b0;
        end
    end

    always_comb begin
        rep_lead = rep_cnt;
        job.has_cp = has_cp;
        job.cp     = cp;
        if (relead) begin
            if (data_byte[7] == AsciiTag) begin
                job.has_cp = 1'b1;
                job.cp     = CpW'(data_byte);
            end else if (!lead_ok) begin
                rep_lead = rep_cnt + CountW'(1);
            end else if (text_end) begin
                rep_lead = rep_cnt + CountW'(1);
            end
        end
        job.item_cnt = rep_lead + CountW'(job.has_cp);
        job.text_end = text_end;
    end

    // state after the lead, and end of text always leaves the decoder idle
    always_comb begin
        state_nxt = state_seq;
        if (relead && lead_ok && !text_end) begin
            state_nxt = '{partial_value: lead_bits, bytes_still_needed: lead_need,
                          continuations_taken: 2'd0};
        end
        if (text_end) begin
            state_nxt = IdleState;
        end
    end

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the utf-8 code point decoder core
`timescale 1ns / 100ps

module testbench;
    import utf8dec_pkg::*;

    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           repl;
        logic           run_last;
        logic           text_done;
    } cp_result_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             last;
        logic             typed;
        cp_result_t       want;
    } stim_row_t;

    typedef struct packed {
        logic       typed;
        cp_result_t want;
    } row_hint_t;

    localparam cp_result_t NoWant     = '0;
    localparam int         QuietLimit = 2000;
    localparam int         StallLen   = 64;
    localparam int         NumRows    = 25;

    // directed bytes; fixed results only where they are obvious
    localparam stim_row_t DirectedRows [NumRows] = '{
        '{8'h00, 1'b0, 1'b1, '{21'h000000, 1'b0, 1'b1, 1'b0}},
        '{8'h7F, 1'b0, 1'b1, '{21'h00007F, 1'b0, 1'b1, 1'b0}},
        '{8'h80, 1'b0, 1'b1, '{ReplCp, 1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{ReplCp, 1'b1, 1'b1, 1'b0}},
        '{8'hF8, 1'b0, 1'b1, '{ReplCp, 1'b1, 1'b1, 1'b0}},
        '{8'hC2, 1'b0, 1'b0, NoWant},
        '{8'hA9, 1'b0, 1'b0, NoWant},
        '{8'hE2, 1'b0, 1'b0, NoWant},
        '{8'h82, 1'b0, 1'b0, NoWant},
        '{8'hAC, 1'b0, 1'b0, NoWant},
        '{8'hF7, 1'b0, 1'b0, NoWant},
        '{8'hBF, 1'b0, 1'b0, NoWant},
        '{8'hBF, 1'b0, 1'b0, NoWant},
        '{8'hBF, 1'b0, 1'b0, NoWant},
        '{8'hF0, 1'b0, 1'b0, NoWant},
        '{8'h90, 1'b0, 1'b0, NoWant},
        '{8'h41, 1'b0, 1'b0, NoWant},
        '{8'hF4, 1'b0, 1'b0, NoWant},
        '{8'h8F, 1'b0, 1'b0, NoWant},
        '{8'hBF, 1'b0, 1'b0, NoWant},
        '{8'h41, 1'b0, 1'b0, NoWant},
        '{8'hE2, 1'b0, 1'b0, NoWant},
        '{8'h82, 1'b1, 1'b0, NoWant},
        '{8'hC2, 1'b1, 1'b1, '{ReplCp, 1'b1, 1'b1, 1'b1}},
        '{8'h41, 1'b1, 1'b1, '{21'h000041, 1'b0, 1'b1, 1'b1}}
    };

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [ByteW-1:0] s_data_byte;
    logic             s_text_end;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [CpW-1:0]   m_code_point;
    logic             m_is_replacement;
    logic             m_run_last;
    logic             m_text_done;

    // decoder state mirrored by the predictor
    logic [CpW-1:0] seq_bits  = '0;
    logic [1:0]     seq_left  = '0;
    logic [1:0]     seq_taken = '0;

    cp_result_t pending_cps [$];
    row_hint_t  row_hints [$];

    int tx_gap_pct = 0;
    int rx_gap_pct = 0;
    int stall_requests = 0;
    int stalls_started = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_taken = 0;
    int cps_checked = 0;
    int repl_seen = 0;
    int texts_done = 0;

    utf8_codepoint_decoder_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_text_end       (s_text_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_code_point     (m_code_point),
        .m_is_replacement (m_is_replacement),
        .m_run_last       (m_run_last),
        .m_text_done      (m_text_done)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void put_cp(ref cp_result_t q [$], input logic [CpW-1:0] cp,
                                   input logic repl);
        q.insert(q.size(), cp_result_t'{cp, repl, 1'b0, 1'b0});
    endfunction

    function automatic void seq_clear();
        seq_bits  = '0;
        seq_left  = '0;
        seq_taken = '0;
    endfunction

    // one replacement for the lead and one per continuation taken
    function automatic void flush_seq(ref cp_result_t q [$]);
        for (int k = 0; k <= int'(seq_taken); k++) begin
            put_cp(q, ReplCp, 1'b1);
        end
        seq_clear();
    endfunction

    // code points caused by one accepted byte
    function automatic void decode_byte(input logic [ByteW-1:0] b, input logic last,
                                        ref cp_result_t q [$]);
        int         first_idx;
        logic       relead;
        first_idx = q.size();
        relead = 1'b1;
        if (seq_left != 2'd0) begin
            if (b[7:6] == ContTag) begin
                relead = 1'b0;
                seq_bits  = {seq_bits[CpW-7:0], b[5:0]};
                seq_left  = seq_left - 2'd1;
                seq_taken = seq_taken + 2'd1;
                if (seq_left == 2'd0) begin
                    put_cp(q, seq_bits, 1'b0);
                    seq_clear();
                end else if (last) begin
                    flush_seq(q);
                end
            end else begin
                flush_seq(q);
            end
        end
        if (relead) begin
            if (b[7] == AsciiTag) begin
                put_cp(q, CpW'(b), 1'b0);
            end else if (b[7:5] == Lead2Tag || b[7:4] == Lead3Tag || b[7:3] == Lead4Tag) begin
                if (last) begin
                    // lead with nothing after it
                    put_cp(q, ReplCp, 1'b1);
                end else if (b[7:5] == Lead2Tag) begin
                    seq_bits = CpW'(b[4:0]);
                    seq_left = 2'd1;
                end else if (b[7:4] == Lead3Tag) begin
                    seq_bits = CpW'(b[3:0]);
                    seq_left = 2'd2;
                end else begin
                    seq_bits = CpW'(b[2:0]);
                    seq_left = 2'd3;
                end
                seq_taken = 2'd0;
            end else begin
                put_cp(q, ReplCp, 1'b1);
            end
        end
        if (q.size() > first_idx) begin
            q[q.size() - 1].run_last  = 1'b1;
            q[q.size() - 1].text_done = last;
        end
        if (last) begin
            seq_clear();
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // receiver: random back-pressure, plus long holds on request
    always @(negedge aclk) begin
        if (stalls_started != stall_requests) begin
            stalls_started = stall_requests;
            stall_left = StallLen;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_gap_pct);
        end
    end

    // both channels observed at the rising edge: check first, then predict
    always @(posedge aclk) begin
        cp_result_t got;
        cp_result_t want;
        cp_result_t fresh [$];
        row_hint_t  hint;
        logic       moved;
        moved = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                moved = 1'b1;
                got = '{m_code_point, m_is_replacement, m_run_last, m_text_done};
                cps_checked++;
                if (got.repl) repl_seen++;
                if (got.text_done) texts_done++;
                if (pending_cps.size() == 0) begin
                    $error("unexpected code point 0x%0h with nothing pending", got.cp);
                    mismatches++;
                end else begin
                    want = pending_cps.pop_front();
                    check_field("code_point", int'(want.cp), int'(got.cp));
                    check_field("is_replacement", int'(want.repl), int'(got.repl));
                    check_field("run_last", int'(want.run_last), int'(got.run_last));
                    check_field("text_done", int'(want.text_done), int'(got.text_done));
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                bytes_taken++;
                hint = row_hints.pop_front();
                fresh.delete();
                decode_byte(s_data_byte, s_text_end, fresh);
                if (hint.typed) begin
                    pending_cps.insert(pending_cps.size(), hint.want);
                end else begin
                    pending_cps = {pending_cps, fresh};
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("watchdog: no transaction for %0d cycles", QuietLimit);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // offer one byte from a falling edge; returns at the falling edge after acceptance
    task automatic push_byte(input logic [ByteW-1:0] b, input logic last, input logic typed,
                             input cp_result_t want);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        row_hints.insert(row_hints.size(), row_hint_t'{typed, want});
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_text_end  <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_cps.size() != 0) @(negedge aclk);
    endtask

    // mostly well-formed sequences with random payload bits, some broken ones and noise
    task automatic send_random_text(input int n_bytes);
        logic [ByteW-1:0] chunk [$];
        int               sent;
        int               kind;
        int               len;
        int               cut;
        logic             ends;
        sent = 0;
        while (sent < n_bytes) begin
            chunk.delete();
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                chunk.insert(chunk.size(), {1'b0, 7'($urandom)});
            end else if (kind < 90) begin
                len = (kind < 45) ? 2 : (kind < 60) ? 3 : (kind < 75) ? 4 :
                      $urandom_range(2, 4);
                case (len)
                    2: chunk.insert(chunk.size(), {Lead2Tag, 5'($urandom)});
                    3: chunk.insert(chunk.size(), {Lead3Tag, 4'($urandom)});
                    default: chunk.insert(chunk.size(), {Lead4Tag, 3'($urandom)});
                endcase
                for (int k = 1; k < len; k++) chunk.insert(chunk.size(), {ContTag, 6'($urandom)});
                if (kind >= 75) begin
                    // cut short, then a stray byte of any kind
                    cut = $urandom_range(1, len - 1);
                    while (chunk.size() > cut) void'(chunk.pop_back());
                    chunk.insert(chunk.size(), 8'($urandom));
                end
            end else begin
                chunk.insert(chunk.size(), 8'($urandom));
            end
            foreach (chunk[i]) begin
                ends = (i == chunk.size() - 1) ? ($urandom_range(0, 7) == 0)
                                               : ($urandom_range(0, 29) == 0);
                push_byte(chunk[i], ends, 1'b0, NoWant);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        s_text_end  = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_gap_pct = 6;
        rx_gap_pct = 59;
        for (int r = 0; r < NumRows; r++) begin
            push_byte(DirectedRows[r].data, DirectedRows[r].last, DirectedRows[r].typed,
                      DirectedRows[r].want);
        end
        drain_outputs();
        send_random_text(70);

        tx_gap_pct = 59;
        rx_gap_pct = 6;
        send_random_text(70);
        drain_outputs();

        // full rate with one long receiver hold so the input backs up
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        stall_requests++;
        send_random_text(70);

        drain_outputs();
        repeat (8) @(posedge aclk);
        $display("covered %0d bytes (%0d directed) and %0d code points", bytes_taken,
                 NumRows, cps_checked);
        $display("%0d replacements, %0d text ends, %0d mismatches", repl_seen, texts_done,
                 mismatches);
        if (mismatches == 0 && pending_cps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/utf8dec_pkg.sv
hw/rtl/utf8dec_step.sv
hw/rtl/utf8_codepoint_decoder_core.sv
dv/testbench.sv
